[rtl/core/vicrf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Video chip register file package
// Shared opcode type, register addresses and the request and response records
// passed between the core and its register bank.
// ----------------------------------------------------------------------------
package vicrf_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LINE  = 2'd2,
    OP_COLL  = 2'd3
  } opcode_e;

  localparam logic [5:0] ADDR_SPR_MSBS  = 6'h10;
  localparam logic [5:0] ADDR_CTRL1     = 6'h11;
  localparam logic [5:0] ADDR_RASTER    = 6'h12;
  localparam logic [5:0] ADDR_SPR_EN    = 6'h15;
  localparam logic [5:0] ADDR_CTRL2     = 6'h16;
  localparam logic [5:0] ADDR_SPR_YEXP  = 6'h17;
  localparam logic [5:0] ADDR_MEM_PTR   = 6'h18;
  localparam logic [5:0] ADDR_IRQ_FLAG  = 6'h19;
  localparam logic [5:0] ADDR_IRQ_MASK  = 6'h1A;
  localparam logic [5:0] ADDR_SPR_PRIO  = 6'h1B;
  localparam logic [5:0] ADDR_SPR_MC    = 6'h1C;
  localparam logic [5:0] ADDR_SPR_XEXP  = 6'h1D;
  localparam logic [5:0] ADDR_SPR_COLL  = 6'h1E;
  localparam logic [5:0] ADDR_BG_COLL   = 6'h1F;
  localparam logic [5:0] ADDR_GCOL_LO   = 6'h20;
  localparam logic [5:0] ADDR_GCOL_HI   = 6'h26;
  localparam logic [5:0] ADDR_SCOL_LO   = 6'h27;
  localparam logic [5:0] ADDR_SCOL_HI   = 6'h2E;

  localparam logic [2:0] SLOT_EN   = 3'd0;
  localparam logic [2:0] SLOT_YEXP = 3'd1;
  localparam logic [2:0] SLOT_PTR  = 3'd2;
  localparam logic [2:0] SLOT_PRIO = 3'd3;
  localparam logic [2:0] SLOT_MC   = 3'd4;
  localparam logic [2:0] SLOT_XEXP = 3'd5;
  localparam int unsigned NumSlots = 6;

  localparam logic [8:0] BADLINE_FIRST = 9'h030;
  localparam logic [8:0] BADLINE_LAST  = 9'h0F7;

  localparam logic [3:0] FLAG_RASTER = 4'b0001;
  localparam logic [3:0] FLAG_BG     = 4'b0010;
  localparam logic [3:0] FLAG_SPR    = 4'b0100;

  typedef struct packed {
    opcode_e     opcode;
    logic [5:0]  reg_addr;
    logic [7:0]  write_data;
    logic [8:0]  line_number;
    logic [7:0]  sprite_hit_mask;
    logic [7:0]  background_hit_mask;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
    logic       bad_line;
  } rsp_t;

endpackage
`default_nettype wire

[rtl/core/vicrf_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Video chip register bank
// Holds all register state and carries out one request per enabled cycle,
// giving the read data from the state it finds and the interrupt level from the state it leaves.
// ----------------------------------------------------------------------------
module vicrf_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            exec_i,
  input  vicrf_pkg::req_t req_i,
  output vicrf_pkg::rsp_t rsp_o
);
  import vicrf_pkg::*;

  logic [7:0] spr_xl_q [8];
  logic [7:0] spr_xl_d [8];
  logic [7:0] spr_y_q [8];
  logic [7:0] spr_y_d [8];
  logic [7:0] flag_byte_q [NumSlots];
  logic [7:0] flag_byte_d [NumSlots];
  logic [3:0] gcol_q [7];
  logic [3:0] gcol_d [7];
  logic [3:0] scol_q [8];
  logic [3:0] scol_d [8];
  logic [7:0] spr_msbs_q, spr_msbs_d;
  logic [7:0] ctrl1_q, ctrl1_d;
  logic [7:0] ctrl2_q, ctrl2_d;
  logic [8:0] raster_cmp_q, raster_cmp_d;
  logic [8:0] cur_line_q, cur_line_d;
  logic [3:0] irq_flags_q, irq_flags_d;
  logic [3:0] irq_mask_q, irq_mask_d;
  logic [7:0] spr_coll_q, spr_coll_d;
  logic [7:0] bg_coll_q, bg_coll_d;

  logic [5:0] addr;
  logic [2:0] spr_idx;
  logic [2:0] scol_idx;
  logic       is_gcol;
  logic       is_scol;
  logic       slot_hit;
  logic [2:0] slot;
  logic [8:0] new_cmp;
  logic       irq_now;

  assign addr     = req_i.reg_addr;
  assign spr_idx  = addr[3:1];
  assign scol_idx = addr[2:0] + 3'd1;
  assign is_gcol  = (addr >= ADDR_GCOL_LO) && (addr <= ADDR_GCOL_HI);
  assign is_scol  = (addr >= ADDR_SCOL_LO) && (addr <= ADDR_SCOL_HI);
  assign irq_now  = |(irq_flags_q & irq_mask_q);

  always_comb begin
    slot_hit = 1'b1;
    case (addr)
      ADDR_SPR_EN:   slot = SLOT_EN;
      ADDR_SPR_YEXP: slot = SLOT_YEXP;
      ADDR_MEM_PTR:  slot = SLOT_PTR;
      ADDR_SPR_PRIO: slot = SLOT_PRIO;
      ADDR_SPR_MC:   slot = SLOT_MC;
      ADDR_SPR_XEXP: slot = SLOT_XEXP;
      default: begin
        slot     = SLOT_EN;
        slot_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    spr_xl_d     = spr_xl_q;
    spr_y_d      = spr_y_q;
    flag_byte_d  = flag_byte_q;
    gcol_d       = gcol_q;
    scol_d       = scol_q;
    spr_msbs_d   = spr_msbs_q;
    ctrl1_d      = ctrl1_q;
    ctrl2_d      = ctrl2_q;
    raster_cmp_d = raster_cmp_q;
    cur_line_d   = cur_line_q;
    irq_flags_d  = irq_flags_q;
    irq_mask_d   = irq_mask_q;
    spr_coll_d   = spr_coll_q;
    bg_coll_d    = bg_coll_q;
    new_cmp      = raster_cmp_q;
    rsp_o.read_data = 8'hFF;
    rsp_o.bad_line  = 1'b0;

    case (req_i.opcode)
      OP_READ: begin
        if (addr < ADDR_SPR_MSBS) begin
          rsp_o.read_data = addr[0] ? spr_y_q[spr_idx] : spr_xl_q[spr_idx];
        end else if (is_gcol) begin
          rsp_o.read_data = {4'hF, gcol_q[addr[2:0]]};
        end else if (is_scol) begin
          rsp_o.read_data = {4'hF, scol_q[scol_idx]};
        end else if (slot_hit) begin
          rsp_o.read_data = flag_byte_q[slot];
          if (addr == ADDR_MEM_PTR) begin
            rsp_o.read_data[0] = 1'b1;
          end
        end else begin
          case (addr)
            ADDR_SPR_MSBS: rsp_o.read_data = spr_msbs_q;
            ADDR_CTRL1:    rsp_o.read_data = {cur_line_q[8], ctrl1_q[6:0]};
            ADDR_RASTER:   rsp_o.read_data = cur_line_q[7:0];
            ADDR_CTRL2:    rsp_o.read_data = ctrl2_q | 8'hC0;
            ADDR_IRQ_FLAG: rsp_o.read_data = {irq_now, 3'b111, irq_flags_q};
            ADDR_IRQ_MASK: rsp_o.read_data = {4'hF, irq_mask_q};
            ADDR_SPR_COLL: begin
              rsp_o.read_data = spr_coll_q;
              spr_coll_d      = 8'h00;
            end
            ADDR_BG_COLL: begin
              rsp_o.read_data = bg_coll_q;
              bg_coll_d       = 8'h00;
            end
            default: rsp_o.read_data = 8'hFF;
          endcase
        end
      end
      OP_WRITE: begin
        if (addr < ADDR_SPR_MSBS) begin
          if (addr[0]) begin
            spr_y_d[spr_idx] = req_i.write_data;
          end else begin
            spr_xl_d[spr_idx] = req_i.write_data;
          end
        end else if (is_gcol) begin
          gcol_d[addr[2:0]] = req_i.write_data[3:0];
        end else if (is_scol) begin
          scol_d[scol_idx] = req_i.write_data[3:0];
        end else if (slot_hit) begin
          flag_byte_d[slot] = req_i.write_data;
        end else begin
          case (addr)
            ADDR_SPR_MSBS: spr_msbs_d = req_i.write_data;
            ADDR_CTRL1: begin
              ctrl1_d = req_i.write_data;
              new_cmp = {req_i.write_data[7], raster_cmp_q[7:0]};
            end
            ADDR_RASTER:   new_cmp = {raster_cmp_q[8], req_i.write_data};
            ADDR_CTRL2:    ctrl2_d = req_i.write_data;
            ADDR_IRQ_FLAG: irq_flags_d = irq_flags_q & ~req_i.write_data[3:0];
            ADDR_IRQ_MASK: irq_mask_d = req_i.write_data[3:0];
            default: ;
          endcase
          if ((new_cmp != raster_cmp_q) && (cur_line_q == new_cmp)) begin
            irq_flags_d = irq_flags_d | FLAG_RASTER;
          end
          raster_cmp_d = new_cmp;
        end
      end
      OP_LINE: begin
        cur_line_d = req_i.line_number;
        if (req_i.line_number == raster_cmp_q) begin
          irq_flags_d = irq_flags_q | FLAG_RASTER;
        end
        rsp_o.bad_line = ctrl1_q[4] && (req_i.line_number >= BADLINE_FIRST) &&
                         (req_i.line_number <= BADLINE_LAST) &&
                         (req_i.line_number[2:0] == ctrl1_q[2:0]);
      end
      OP_COLL: begin
        if ((spr_coll_q == 8'h00) && (req_i.sprite_hit_mask != 8'h00)) begin
          irq_flags_d = irq_flags_d | FLAG_SPR;
        end
        if ((bg_coll_q == 8'h00) && (req_i.background_hit_mask != 8'h00)) begin
          irq_flags_d = irq_flags_d | FLAG_BG;
        end
        spr_coll_d = spr_coll_q | req_i.sprite_hit_mask;
        bg_coll_d  = bg_coll_q | req_i.background_hit_mask;
      end
      default: ;
    endcase

    rsp_o.irq_out = |(irq_flags_d & irq_mask_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        spr_xl_q[i] <= '0;
        spr_y_q[i]  <= '0;
        scol_q[i]   <= '0;
      end
      for (int i = 0; i < NumSlots; i++) begin
        flag_byte_q[i] <= '0;
      end
      for (int i = 0; i < 7; i++) begin
        gcol_q[i] <= '0;
      end
      spr_msbs_q   <= '0;
      ctrl1_q      <= '0;
      ctrl2_q      <= '0;
      raster_cmp_q <= '0;
      cur_line_q   <= '0;
      irq_flags_q  <= '0;
      irq_mask_q   <= '0;
      spr_coll_q   <= '0;
      bg_coll_q    <= '0;
    end else if (exec_i) begin
      spr_xl_q     <= spr_xl_d;
      spr_y_q      <= spr_y_d;
      scol_q       <= scol_d;
      flag_byte_q  <= flag_byte_d;
      gcol_q       <= gcol_d;
      spr_msbs_q   <= spr_msbs_d;
      ctrl1_q      <= ctrl1_d;
      ctrl2_q      <= ctrl2_d;
      raster_cmp_q <= raster_cmp_d;
      cur_line_q   <= cur_line_d;
      irq_flags_q  <= irq_flags_d;
      irq_mask_q   <= irq_mask_d;
      spr_coll_q   <= spr_coll_d;
      bg_coll_q    <= bg_coll_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/video_chip_register_file_irq_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Video chip register file and interrupt core
// Bus register reads and writes, raster line starts and collision reports.
// ----------------------------------------------------------------------------
// Each request on the input channel carries an opcode and its operands and
// produces exactly one response: the read data (255 for anything but a read),
// the interrupt line level after the request, and the bad line indication.
// A request is taken when in_valid_i is high and in_stall_o is low; a response
// is taken when out_valid_o is high and out_stall_i is low.
// The request is captured in an input register; the register bank then
// executes it and the response register loads. One request per cycle is
// sustained while the receiver does not stall; the register bank works out
// the whole response of a request combinationally from its registers.
// When the receiver stalls, the response holds and the input register keeps
// one more request, so in_stall_o rises only when both stages are full.
// Reset clears every register of the register bank to zero and empties both
// stages.
// ----------------------------------------------------------------------------
module video_chip_register_file_irq_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [5:0] reg_addr_i,
  input  logic [7:0] write_data_i,
  input  logic [8:0] line_number_i,
  input  logic [7:0] sprite_hit_mask_i,
  input  logic [7:0] background_hit_mask_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       irq_out_o,
  output logic       bad_line_o
);
  import vicrf_pkg::*;

  logic  s1_valid_q, s1_valid_d;
  req_t  s1_req_q;
  logic  out_valid_q, out_valid_d;
  rsp_t  out_rsp_q;
  rsp_t  bank_rsp;
  logic  advance;
  logic  exec;
  logic  in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign exec       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = in_stall_o ? s1_valid_q : in_valid_i;
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q.opcode              <= opcode_e'(opcode_i);
      s1_req_q.reg_addr            <= reg_addr_i;
      s1_req_q.write_data          <= write_data_i;
      s1_req_q.line_number         <= line_number_i;
      s1_req_q.sprite_hit_mask     <= sprite_hit_mask_i;
      s1_req_q.background_hit_mask <= background_hit_mask_i;
    end
    if (exec) begin
      out_rsp_q <= bank_rsp;
    end
  end

  vicrf_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (exec),
    .req_i  (s1_req_q),
    .rsp_o  (bank_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_rsp_q.read_data;
  assign irq_out_o   = out_rsp_q.irq_out;
  assign bad_line_o  = out_rsp_q.bad_line;

endmodule
`default_nettype wire

[rtl/core/vicrf_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Video chip register file port checker
// Checks the handshake behavior seen on the ports of the core.
// ----------------------------------------------------------------------------
module vicrf_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_o,
  input  logic       out_valid_o,
  input  logic       out_stall_i,
  input  logic [7:0] read_data_o,
  input  logic       irq_out_o,
  input  logic       bad_line_o
);

  // The input side only backs up when a response is waiting and blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the response register could move");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> (!out_valid_o && !in_stall_o))
    else $error("pipeline not empty during reset");

  // A blocked response stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("response dropped while stalled");

  // A blocked response keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(read_data_o) && $stable(irq_out_o) && $stable(bad_line_o)))
    else $error("response payload changed while stalled");

endmodule

bind video_chip_register_file_irq_core vicrf_checker u_vicrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o),
  .irq_out_o   (irq_out_o),
  .bad_line_o  (bad_line_o)
);
`default_nettype wire

[tb/sv/tb_video_chip_register_file_irq_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Video chip register file and interrupt core testbench
// Drives bus reads and writes, raster line starts and collision reports in
// random bursts against a stalling receiver. Every request is run through a
// shadow of the register bank when it is taken. Each response is checked
// against the oldest predicted response.
// ----------------------------------------------------------------------------
module tb_video_chip_register_file_irq_core;
  import vicrf_pkg::*;

  localparam int RandomRequests = 1400;
  localparam int CycleLimit     = 200000;
  localparam int DrainCycles    = 10;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] opcode_i = '0;
  logic [5:0] reg_addr_i = '0;
  logic [7:0] write_data_i = '0;
  logic [8:0] line_number_i = '0;
  logic [7:0] sprite_hit_mask_i = '0;
  logic [7:0] background_hit_mask_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] read_data_o;
  logic       irq_out_o;
  logic       bad_line_o;

  video_chip_register_file_irq_core uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .opcode_i              (opcode_i),
    .reg_addr_i            (reg_addr_i),
    .write_data_i          (write_data_i),
    .line_number_i         (line_number_i),
    .sprite_hit_mask_i     (sprite_hit_mask_i),
    .background_hit_mask_i (background_hit_mask_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .read_data_o           (read_data_o),
    .irq_out_o             (irq_out_o),
    .bad_line_o            (bad_line_o)
  );

  req_t pending_req_q[$];
  rsp_t expected_rsp_q[$];
  int   error_cnt = 0;
  int   cycle_cnt = 0;
  int   burst_left;
  int   gap_left;
  int   stall_mode;
  int   mode_left;

  // Shadow of the register bank.
  logic [7:0] sh_x_lo[8];
  logic [7:0] sh_y[8];
  logic [7:0] sh_x_hi;
  logic [7:0] sh_ctrl1;
  logic [7:0] sh_ctrl2;
  logic [8:0] sh_cmp;
  logic [8:0] sh_line;
  logic [7:0] sh_flag_bytes[NumSlots];
  logic [3:0] sh_irq_flags;
  logic [3:0] sh_irq_mask;
  logic [7:0] sh_spr_coll;
  logic [7:0] sh_bg_coll;
  logic [3:0] sh_gcol[7];
  logic [3:0] sh_scol[8];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch: %s: got %0h, expected %0h", what, got, want);
    error_cnt++;
  endtask

  task automatic push_req(input opcode_e op, input logic [5:0] a, input logic [7:0] d,
                          input logic [8:0] ln, input logic [7:0] sh, input logic [7:0] bh);
    req_t r;
    r.opcode              = op;
    r.reg_addr            = a;
    r.write_data          = d;
    r.line_number         = ln;
    r.sprite_hit_mask     = sh;
    r.background_hit_mask = bh;
    pending_req_q.push_back(r);
  endtask

  task automatic predict_register_access(input req_t r, output rsp_t e);
    logic [5:0] a;
    logic [5:0] off;
    logic [7:0] rd;
    logic       bad;
    logic       slot_hit;
    logic [2:0] slot;
    logic       cmp_wr;
    logic [8:0] new_cmp;
    a        = r.reg_addr;
    rd       = 8'hFF;
    bad      = 1'b0;
    slot_hit = 1'b1;
    slot     = SLOT_EN;
    cmp_wr   = 1'b0;
    new_cmp  = sh_cmp;
    case (a)
      ADDR_SPR_EN:   slot = SLOT_EN;
      ADDR_SPR_YEXP: slot = SLOT_YEXP;
      ADDR_MEM_PTR:  slot = SLOT_PTR;
      ADDR_SPR_PRIO: slot = SLOT_PRIO;
      ADDR_SPR_MC:   slot = SLOT_MC;
      ADDR_SPR_XEXP: slot = SLOT_XEXP;
      default:       slot_hit = 1'b0;
    endcase
    case (r.opcode)
      OP_READ: begin
        if (a < ADDR_SPR_MSBS) begin
          rd = a[0] ? sh_y[a[3:1]] : sh_x_lo[a[3:1]];
        end else if (a >= ADDR_GCOL_LO && a <= ADDR_GCOL_HI) begin
          off = a - ADDR_GCOL_LO;
          rd  = {4'hF, sh_gcol[off[2:0]]};
        end else if (a >= ADDR_SCOL_LO && a <= ADDR_SCOL_HI) begin
          off = a - ADDR_SCOL_LO;
          rd  = {4'hF, sh_scol[off[2:0]]};
        end else if (slot_hit) begin
          rd = sh_flag_bytes[slot];
          if (a == ADDR_MEM_PTR) rd[0] = 1'b1;
        end else begin
          case (a)
            ADDR_SPR_MSBS: rd = sh_x_hi;
            ADDR_CTRL1:    rd = {sh_line[8], sh_ctrl1[6:0]};
            ADDR_RASTER:   rd = sh_line[7:0];
            ADDR_CTRL2:    rd = sh_ctrl2 | 8'hC0;
            ADDR_IRQ_FLAG: rd = {|(sh_irq_flags & sh_irq_mask), 3'b111, sh_irq_flags};
            ADDR_IRQ_MASK: rd = {4'hF, sh_irq_mask};
            ADDR_SPR_COLL: begin
              rd          = sh_spr_coll;
              sh_spr_coll = '0;
            end
            ADDR_BG_COLL: begin
              rd         = sh_bg_coll;
              sh_bg_coll = '0;
            end
            default:       rd = 8'hFF;
          endcase
        end
      end
      OP_WRITE: begin
        if (a < ADDR_SPR_MSBS) begin
          if (a[0]) sh_y[a[3:1]] = r.write_data;
          else sh_x_lo[a[3:1]] = r.write_data;
        end else if (a >= ADDR_GCOL_LO && a <= ADDR_GCOL_HI) begin
          off = a - ADDR_GCOL_LO;
          sh_gcol[off[2:0]] = r.write_data[3:0];
        end else if (a >= ADDR_SCOL_LO && a <= ADDR_SCOL_HI) begin
          off = a - ADDR_SCOL_LO;
          sh_scol[off[2:0]] = r.write_data[3:0];
        end else if (slot_hit) begin
          sh_flag_bytes[slot] = r.write_data;
        end else begin
          case (a)
            ADDR_SPR_MSBS: sh_x_hi = r.write_data;
            ADDR_CTRL1: begin
              sh_ctrl1 = r.write_data;
              cmp_wr   = 1'b1;
              new_cmp  = {r.write_data[7], sh_cmp[7:0]};
            end
            ADDR_RASTER: begin
              cmp_wr  = 1'b1;
              new_cmp = {sh_cmp[8], r.write_data};
            end
            ADDR_CTRL2:    sh_ctrl2 = r.write_data;
            ADDR_IRQ_FLAG: sh_irq_flags = sh_irq_flags & ~r.write_data[3:0];
            ADDR_IRQ_MASK: sh_irq_mask = r.write_data[3:0];
            default: ;
          endcase
        end
        if (cmp_wr) begin
          // Only a change of the compare value onto the current line raises the flag.
          if (new_cmp != sh_cmp && new_cmp == sh_line) sh_irq_flags |= FLAG_RASTER;
          sh_cmp = new_cmp;
        end
      end
      OP_LINE: begin
        sh_line = r.line_number;
        if (sh_line == sh_cmp) sh_irq_flags |= FLAG_RASTER;
        bad = sh_ctrl1[4] && r.line_number >= BADLINE_FIRST &&
              r.line_number <= BADLINE_LAST && r.line_number[2:0] == sh_ctrl1[2:0];
      end
      default: begin
        if (sh_spr_coll == '0 && r.sprite_hit_mask != '0) sh_irq_flags |= FLAG_SPR;
        if (sh_bg_coll == '0 && r.background_hit_mask != '0) sh_irq_flags |= FLAG_BG;
        sh_spr_coll |= r.sprite_hit_mask;
        sh_bg_coll  |= r.background_hit_mask;
      end
    endcase
    e.read_data = rd;
    e.irq_out   = |(sh_irq_flags & sh_irq_mask);
    e.bad_line  = bad;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    rsp_t exp_rsp;
    req_t nxt;
    if (!rst_ni) begin
      in_valid_i            <= 1'b0;
      opcode_i              <= '0;
      reg_addr_i            <= '0;
      write_data_i          <= '0;
      line_number_i         <= '0;
      sprite_hit_mask_i     <= '0;
      background_hit_mask_i <= '0;
      burst_left = 1;
      gap_left   = 0;
      for (int i = 0; i < 8; i++) begin
        sh_x_lo[i] = '0;
        sh_y[i]    = '0;
        sh_scol[i] = '0;
      end
      for (int i = 0; i < 7; i++) sh_gcol[i] = '0;
      for (int i = 0; i < NumSlots; i++) sh_flag_bytes[i] = '0;
      sh_x_hi      = '0;
      sh_ctrl1     = '0;
      sh_ctrl2     = '0;
      sh_cmp       = '0;
      sh_line      = '0;
      sh_irq_flags = '0;
      sh_irq_mask  = '0;
      sh_spr_coll  = '0;
      sh_bg_coll   = '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_register_access(pending_req_q[0], exp_rsp);
        expected_rsp_q.push_back(exp_rsp);
        void'(pending_req_q.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_req_q.size() != 0) begin
          nxt = pending_req_q[0];
          in_valid_i            <= 1'b1;
          opcode_i              <= nxt.opcode;
          reg_addr_i            <= nxt.reg_addr;
          write_data_i          <= nxt.write_data;
          line_number_i         <= nxt.line_number;
          sprite_hit_mask_i     <= nxt.sprite_hit_mask;
          background_hit_mask_i <= nxt.background_hit_mask;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode = 0;
      mode_left  = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_responses
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("response with no request pending", read_data_o, 8'h00);
      end else begin
        want = expected_rsp_q.pop_front();
        if (read_data_o !== want.read_data)
          report_mismatch("read_data", read_data_o, want.read_data);
        if (irq_out_o !== want.irq_out)
          report_mismatch("irq_out", {7'd0, irq_out_o}, {7'd0, want.irq_out});
        if (bad_line_o !== want.bad_line)
          report_mismatch("bad_line", {7'd0, bad_line_o}, {7'd0, want.bad_line});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_video_chip_register_file_irq_core: done, errors");
      $finish;
    end
  end

  initial begin : run_test
    int         base;
    logic [7:0] d;
    logic [7:0] d2;
    logic [8:0] ln;
    logic [7:0] sh;
    logic [7:0] bh;

    push_req(OP_READ,  6'h00, 8'h00, 9'h000, 8'h00, 8'h00);
    push_req(OP_WRITE, 6'h3F, 8'hFF, 9'h000, 8'h00, 8'h00);
    push_req(OP_READ,  6'h3F, 8'h00, 9'h000, 8'h00, 8'h00);
    push_req(OP_WRITE, 6'h00, 8'hFF, 9'h000, 8'h00, 8'h00);
    push_req(OP_READ,  6'h00, 8'h00, 9'h000, 8'h00, 8'h00);
    push_req(OP_WRITE, ADDR_IRQ_MASK, 8'h0F, 9'h000, 8'h00, 8'h00);
    push_req(OP_LINE,  6'h00, 8'h00, 9'h000, 8'h00, 8'h00);
    push_req(OP_READ,  ADDR_IRQ_FLAG, 8'h00, 9'h000, 8'h00, 8'h00);
    push_req(OP_WRITE, ADDR_IRQ_FLAG, 8'h0F, 9'h000, 8'h00, 8'h00);
    push_req(OP_WRITE, ADDR_CTRL1, 8'h9B, 9'h000, 8'h00, 8'h00);
    push_req(OP_LINE,  6'h00, 8'h00, 9'h1FF, 8'h00, 8'h00);
    push_req(OP_WRITE, ADDR_RASTER, 8'hFF, 9'h000, 8'h00, 8'h00);
    push_req(OP_READ,  ADDR_CTRL1, 8'h00, 9'h000, 8'h00, 8'h00);
    push_req(OP_LINE,  6'h00, 8'h00, 9'h033, 8'h00, 8'h00);
    push_req(OP_LINE,  6'h00, 8'h00, 9'h0FB, 8'h00, 8'h00);
    push_req(OP_LINE,  6'h00, 8'h00, 9'h02B, 8'h00, 8'h00);
    push_req(OP_COLL,  6'h00, 8'h00, 9'h000, 8'hFF, 8'h01);
    push_req(OP_COLL,  6'h00, 8'h00, 9'h000, 8'h01, 8'h80);
    push_req(OP_READ,  ADDR_SPR_COLL, 8'h00, 9'h000, 8'h00, 8'h00);
    push_req(OP_READ,  ADDR_BG_COLL, 8'h00, 9'h000, 8'h00, 8'h00);
    push_req(OP_READ,  ADDR_SPR_COLL, 8'h00, 9'h000, 8'h00, 8'h00);
    push_req(OP_WRITE, ADDR_SCOL_HI, 8'hA5, 9'h000, 8'h00, 8'h00);
    push_req(OP_READ,  ADDR_SCOL_HI, 8'h00, 9'h000, 8'h00, 8'h00);
    push_req(OP_READ,  ADDR_MEM_PTR, 8'h00, 9'h000, 8'h00, 8'h00);
    push_req(OP_WRITE, ADDR_SPR_COLL, 8'h55, 9'h000, 8'h00, 8'h00);
    push_req(OP_READ,  6'h13, 8'h00, 9'h000, 8'h00, 8'h00);

    base = pending_req_q.size();
    while (pending_req_q.size() - base < RandomRequests) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          d  = 8'($urandom);
          d2 = 8'($urandom);
          ln = {d2[7], d};
          if ($urandom_range(0, 3) == 0) ln = 9'($urandom);
          push_req(OP_WRITE, ADDR_RASTER, d, 9'($urandom), 8'($urandom), 8'($urandom));
          push_req(OP_WRITE, ADDR_CTRL1, d2, 9'($urandom), 8'($urandom), 8'($urandom));
          push_req(OP_LINE, 6'($urandom), 8'($urandom), ln, 8'($urandom), 8'($urandom));
          push_req(OP_READ, ADDR_IRQ_FLAG, 8'($urandom), 9'($urandom), 8'($urandom),
                   8'($urandom));
          push_req(OP_WRITE, ADDR_IRQ_FLAG, 8'($urandom), 9'($urandom), 8'($urandom),
                   8'($urandom));
        end
        3, 4: begin
          sh = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
          bh = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
          push_req(OP_COLL, 6'($urandom), 8'($urandom), 9'($urandom), sh, bh);
          push_req(OP_READ, ADDR_IRQ_FLAG, 8'($urandom), 9'($urandom), 8'($urandom),
                   8'($urandom));
          push_req(OP_READ, $urandom_range(0, 1) ? ADDR_SPR_COLL : ADDR_BG_COLL,
                   8'($urandom), 9'($urandom), 8'($urandom), 8'($urandom));
          if ($urandom_range(0, 1))
            push_req(OP_WRITE, ADDR_IRQ_FLAG, 8'($urandom), 9'($urandom), 8'($urandom),
                     8'($urandom));
        end
        5, 6, 7: begin
          push_req(opcode_e'($urandom_range(0, 3)),
                   $urandom_range(0, 1) ? 6'($urandom) : 6'($urandom_range(16, 31)),
                   8'($urandom), 9'($urandom), 8'($urandom), 8'($urandom));
        end
        8: begin
          push_req(OP_WRITE, ADDR_IRQ_MASK, 8'($urandom), 9'($urandom), 8'($urandom),
                   8'($urandom));
        end
        default: begin
          d = 8'($urandom);
          if ($urandom_range(0, 3) != 0) d[4] = 1'b1;
          ln = 9'($urandom_range(32'h28, 32'hFF));
          if ($urandom_range(0, 1)) ln[2:0] = d[2:0];
          push_req(OP_WRITE, ADDR_CTRL1, d, 9'($urandom), 8'($urandom), 8'($urandom));
          push_req(OP_LINE, 6'($urandom), 8'($urandom), ln, 8'($urandom), 8'($urandom));
        end
      endcase
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_req_q.size() != 0 || expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("tb_video_chip_register_file_irq_core: done, clean");
    end else begin
      $display("tb_video_chip_register_file_irq_core: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
